[hw/rtl/sobel_edge_filter_rgb_top_defines.svh]
// assertion helpers for the edge filter
`ifndef SOBEL_EDGE_FILTER_RGB_TOP_DEFINES_SVH
`define SOBEL_EDGE_FILTER_RGB_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SOBEL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("edge filter check failed");

// next-cycle implication
`define SOBEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("edge filter check failed");

`endif

[hw/rtl/sobel_rgb_pkg.sv]
package sobel_rgb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int HEIGHT_MAX = 2048;
	localparam int DIM_MIN    = 3;

	// column counter and line buffer address
	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = $clog2(HEIGHT_MAX);

	// register and compare widths
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CMP_W      = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;

	localparam int PIX_W     = 8;
	localparam int OUT_COL_W = 11;
	localparam int OUT_ROW_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = CFG_DATA_W'(640);
	localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = CFG_DATA_W'(480);

	localparam logic [PIX_W-1:0] SAT_LIMIT = PIX_W'(255);

	// one line buffer entry: row two up and row one up at the same column
	localparam int LINE_W = 2 * PIX_W;

	typedef struct packed {
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		logic [PIX_W-1:0] lum;
		logic             emit;
		logic             full;
	} scan_t;

	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} col3_t;

endpackage

[hw/rtl/sobel_rgb_ifs.sv]
interface sobel_rgb_pix_if;
	import sobel_rgb_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	logic             frame_start;

	modport source (output valid, red, green, blue, frame_start, input ready);
	modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface sobel_rgb_res_if;
	import sobel_rgb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [PIX_W-1:0]     gradient;
	logic [OUT_COL_W-1:0] out_col;
	logic [OUT_ROW_W-1:0] out_row;

	modport source (output valid, gradient, out_col, out_row, input ready);
	modport sink (input valid, gradient, out_col, out_row, output ready);
endinterface

interface sobel_rgb_cfg_if;
	import sobel_rgb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/sobel_edge_filter_rgb_top.sv]
// a result is registered through the line ram read, the window and the output register
// one pixel per clock unless stalled, with one line ram read and one write each cycle
// backpressure on the result side stalls the pipe one stage at a time
// reset: position to column 0 row 0, frame size 640 x 480, window cleared
// the line ram is not cleared: its stale entries only reach border centers, which give 0
`include "sobel_edge_filter_rgb_top_defines.svh"

module sobel_edge_filter_rgb_top (
	input  logic            clk,
	input  logic            arst_n,
	sobel_rgb_pix_if.sink   pix,
	sobel_rgb_res_if.source res,
	sobel_rgb_cfg_if.sink   cfg
);
	import sobel_rgb_pkg::*;

	// handshake and stage enables
	logic  accept;
	logic  s1_adv;
	logic  s2_adv;
	logic  cfg_we;

	scan_t info;

	// stage 1: waiting on the line ram read
	logic  valid_s1;
	scan_t scan_s1;

	// stage 2: window updated, gradient being formed
	logic                 valid_s2;
	logic                 emit_s2;
	logic                 full_s2;
	logic [OUT_COL_W-1:0] col_s2;
	logic [OUT_ROW_W-1:0] row_s2;

	// output register
	logic                 out_valid_q;
	logic [PIX_W-1:0]     gradient_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;

	// line ram and read-during-write bypass
	logic              ram_we;
	logic [LINE_W-1:0] ram_wdata;
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line_rd;
	logic              fwd_hit_q;
	logic [LINE_W-1:0] fwd_data_q;

	col3_t            column;
	logic [PIX_W-1:0] grad;

	// each stage moves when the one after it is empty or moving
	assign s2_adv    = !out_valid_q || res.ready;
	assign s1_adv    = !valid_s2 || s2_adv;
	assign pix.ready = !valid_s1 || s1_adv;
	assign accept    = pix.valid && pix.ready;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	sobel_rgb_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.red         (pix.red),
		.green       (pix.green),
		.blue        (pix.blue),
		.frame_start (pix.frame_start),
		.advance     (accept),
		.info        (info)
	);

	// entry holds {row two up, row one up} for one column
	sobel_rgb_line_ram #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W),
		.DATA_W (LINE_W)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (scan_s1.x),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (info.x),
		.rdata (ram_rdata)
	);

	// a write landing on the address read in the same cycle is bypassed
	assign line_rd    = fwd_hit_q ? fwd_data_q : ram_rdata;
	assign ram_we     = valid_s1 && s1_adv;
	assign ram_wdata  = {line_rd[PIX_W-1:0], scan_s1.lum};

	assign column.top = line_rd[LINE_W-1:PIX_W];
	assign column.mid = line_rd[PIX_W-1:0];
	assign column.bot = scan_s1.lum;

	sobel_rgb_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (ram_we),
		.col_in (column),
		.grad   (grad)
	);

	// stage 1 capture and bypass tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= accept;
			if (accept) begin
				fwd_hit_q <= ram_we && (scan_s1.x == info.x);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scan_s1    <= info;
			fwd_data_q <= ram_wdata;
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			emit_s2 <= scan_s1.emit;
			full_s2 <= scan_s1.full;
			col_s2  <= OUT_COL_W'(scan_s1.x - COL_W'(1));
			row_s2  <= OUT_ROW_W'(scan_s1.y - ROW_W'(1));
		end
	end

	// output register, a result is sent only for pixels past the first row and column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= valid_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && valid_s2) begin
			gradient_q <= full_s2 ? grad : '0;
			out_col_q  <= col_s2;
			out_row_q  <= row_s2;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.gradient = gradient_q;
	assign res.out_col  = out_col_q;
	assign res.out_row  = out_row_q;

	// same-address read and write must arm the bypass
	`SOBEL_ASSERT_NEXT(a_fwd_armed, clk, arst_n, accept && ram_we && (scan_s1.x == info.x), fwd_hit_q)
	// a nonzero gradient never comes from a border center
	`SOBEL_ASSERT_NOW(a_border_zero, clk, arst_n, res.valid && (res.gradient != '0), (res.out_col != '0) && (res.out_row != '0))
	// a stalled stage 2 keeps its transaction
	`SOBEL_ASSERT_NEXT(a_s2_hold, clk, arst_n, valid_s2 && !s2_adv, valid_s2)

endmodule

[hw/rtl/sobel_rgb_line_ram.sv]
module sobel_rgb_line_ram #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/sobel_rgb_scan.sv]
module sobel_rgb_scan (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sobel_rgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sobel_rgb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [sobel_rgb_pkg::PIX_W-1:0]      red,
	input  logic [sobel_rgb_pkg::PIX_W-1:0]      green,
	input  logic [sobel_rgb_pkg::PIX_W-1:0]      blue,
	input  logic                               frame_start,
	input  logic                               advance,
	output sobel_rgb_pkg::scan_t                info
);
	import sobel_rgb_pkg::*;

	// divide by three as multiply by 683 / 2048, exact for sums up to 765
	localparam int          SUM_W       = PIX_W + 2;
	localparam int          LUMA_SHIFT  = 11;
	localparam int          PROD_W      = 2 * SUM_W;
	localparam logic [SUM_W-1:0] LUMA_RECIP = SUM_W'(683);

	logic [CFG_DATA_W-1:0] frame_width_q;
	logic [CFG_DATA_W-1:0] frame_height_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;

	logic [CMP_W-1:0]  w_eff;
	logic [CMP_W-1:0]  h_eff;
	logic [COL_W-1:0]  col0;
	logic [ROW_W-1:0]  row0;
	logic [CMP_W-1:0]  row1;
	logic [COL_W-1:0]  x;
	logic [ROW_W-1:0]  y;
	logic [CMP_W-1:0]  col_inc;
	logic [CMP_W-1:0]  row_inc;
	logic [COL_W-1:0]  col_nxt;
	logic [ROW_W-1:0]  row_nxt;
	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;

	always_comb begin
		// clamp the frame size into its legal range
		w_eff = CMP_W'(frame_width_q);
		if (w_eff < CMP_W'(DIM_MIN)) begin
			w_eff = CMP_W'(DIM_MIN);
		end else if (w_eff > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end
		h_eff = CMP_W'(frame_height_q);
		if (h_eff < CMP_W'(DIM_MIN)) begin
			h_eff = CMP_W'(DIM_MIN);
		end else if (h_eff > CMP_W'(HEIGHT_MAX)) begin
			h_eff = CMP_W'(HEIGHT_MAX);
		end

		col0 = frame_start ? '0 : col_q;
		row0 = frame_start ? '0 : row_q;

		// a column left past a reduced width wraps first
		if (CMP_W'(col0) >= w_eff) begin
			x    = '0;
			row1 = CMP_W'(row0) + CMP_W'(1);
		end else begin
			x    = col0;
			row1 = CMP_W'(row0);
		end
		y = (row1 >= h_eff) ? '0 : ROW_W'(row1);

		col_inc = CMP_W'(x) + CMP_W'(1);
		row_inc = CMP_W'(y) + CMP_W'(1);
		if (col_inc >= w_eff) begin
			col_nxt = '0;
			row_nxt = (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
		end else begin
			col_nxt = COL_W'(col_inc);
			row_nxt = y;
		end

		sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
		prod = PROD_W'(sum) * PROD_W'(LUMA_RECIP);

		info.x    = x;
		info.y    = y;
		info.lum  = prod[LUMA_SHIFT +: PIX_W];
		info.emit = (x != '0) && (y != '0);
		info.full = (x > COL_W'(1)) && (y > ROW_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			col_q          <= '0;
			row_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (advance) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

endmodule

[hw/rtl/sobel_rgb_window.sv]
module sobel_rgb_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  sobel_rgb_pkg::col3_t          col_in,
	output logic [sobel_rgb_pkg::PIX_W-1:0] grad
);
	import sobel_rgb_pkg::*;

	localparam int G_W   = PIX_W + 3;
	localparam int MAG_W = PIX_W + 2;

	logic [PIX_W-1:0] win_q [3][3];

	logic [G_W-1:0]   gx;
	logic [G_W-1:0]   gy;
	logic [MAG_W-1:0] mag_x;
	logic [MAG_W-1:0] mag_y;
	logic [G_W-1:0]   total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[k][j] <= '0;
				end
			end
		end else if (shift) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= col_in.top;
			win_q[1][2] <= col_in.mid;
			win_q[2][2] <= col_in.bot;
		end
	end

	// two's complement in G_W bits, true values stay within +-1020
	always_comb begin
		gx = (G_W'(win_q[0][2]) - G_W'(win_q[0][0]))
			+ ((G_W'(win_q[1][2]) - G_W'(win_q[1][0])) << 1)
			+ (G_W'(win_q[2][2]) - G_W'(win_q[2][0]));
		gy = (G_W'(win_q[0][0]) + (G_W'(win_q[0][1]) << 1) + G_W'(win_q[0][2]))
			- (G_W'(win_q[2][0]) + (G_W'(win_q[2][1]) << 1) + G_W'(win_q[2][2]));
		mag_x = gx[G_W-1] ? MAG_W'(-gx) : MAG_W'(gx);
		mag_y = gy[G_W-1] ? MAG_W'(-gy) : MAG_W'(gy);
		total = G_W'(mag_x) + G_W'(mag_y);
		grad  = (total > G_W'(SAT_LIMIT)) ? SAT_LIMIT : PIX_W'(total);
	end

endmodule

[test/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sobel_rgb_pkg::*;

	// watchdog: far above what a full run takes under stalls
	localparam int unsigned CYCLE_LIMIT = 100000;
	// settle time once the expected queue is empty, long enough for the pipe to empty
	localparam int unsigned SETTLE_CYCLES = 8;
	// register indexes the block leaves unused
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             frame_start;
	} rgb_pixel_t;

	typedef struct {
		logic [PIX_W-1:0]     gradient;
		logic [OUT_COL_W-1:0] col;
		logic [OUT_ROW_W-1:0] row;
	} edge_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sobel_rgb_pix_if pix_ch();
	sobel_rgb_res_if res_ch();
	sobel_rgb_cfg_if cfg_ch();

	sobel_edge_filter_rgb_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// 20 ns period
	always #10 clk = ~clk;

	// predicted state of the filter: line buffers, window, scan position, frame size
	logic [PIX_W-1:0]      lum_two_up [MAX_WIDTH];
	logic [PIX_W-1:0]      lum_one_up [MAX_WIDTH];
	logic [PIX_W-1:0]      win [3][3];
	int unsigned           scan_col;
	int unsigned           scan_row;
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;

	// gradients still owed by the block, oldest first
	edge_result_t pending_edges[$];

	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned results_checked = 0;
	int unsigned reg_writes = 0;

	// steady: no idling on either side; drain_hold: keep the result side open
	logic steady = 1'b0;
	logic drain_hold = 1'b0;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		// keep the log short when everything goes wrong
		if (mismatch_count <= 40)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < DIM_MIN)
			return DIM_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// advance the predicted filter by one accepted pixel, queue its gradient if any
	task automatic predict_edge(input rgb_pixel_t px);
		int unsigned  w;
		int unsigned  h;
		int unsigned  x;
		int unsigned  y;
		int unsigned  sum;
		logic [PIX_W-1:0] lum;
		logic [PIX_W-1:0] up2;
		logic [PIX_W-1:0] up1;
		int           tl, tm, tr, ml, mr, bl, bm, br;
		int           gx, gy, mag;
		edge_result_t want;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, HEIGHT_MAX);
		sum = px.red + px.green + px.blue;
		lum = PIX_W'(sum / 3);

		// frame start resets the position before any wrap
		if (px.frame_start) begin
			scan_col = 0;
			scan_row = 0;
		end
		// a column at or past a narrowed width wraps to the next row
		if (scan_col >= w) begin
			scan_col = 0;
			scan_row++;
		end
		if (scan_row >= h)
			scan_row = 0;
		x = scan_col;
		y = scan_row;

		up2 = lum_two_up[x];
		up1 = lum_one_up[x];
		lum_two_up[x] = up1;
		lum_one_up[x] = lum;

		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = up2;
		win[1][2] = up1;
		win[2][2] = lum;

		if (x >= 1 && y >= 1) begin
			mag = 0;
			// first row and first column centers give zero
			if (x >= 2 && y >= 2) begin
				tl = win[0][0]; tm = win[0][1]; tr = win[0][2];
				ml = win[1][0]; mr = win[1][2];
				bl = win[2][0]; bm = win[2][1]; br = win[2][2];
				gx = (tr - tl) + 2 * (mr - ml) + (br - bl);
				gy = (tl + 2 * tm + tr) - (bl + 2 * bm + br);
				mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
				if (mag > SAT_LIMIT)
					mag = SAT_LIMIT;
			end
			want.gradient = PIX_W'(mag);
			want.col = OUT_COL_W'(x - 1);
			want.row = OUT_ROW_W'(y - 1);
			pending_edges.push_back(want);
		end

		// end of row and end of frame wraps
		scan_col = x + 1;
		if (scan_col >= w) begin
			scan_col = 0;
			scan_row = y + 1;
			if (scan_row >= h)
				scan_row = 0;
		end
	endtask

	// one pixel transaction with random idle cycles ahead of it
	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b, input logic fs);
		rgb_pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.frame_start = fs;
		while (!steady && $urandom_range(0, 99) < 15) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.red <= r;
		pix_ch.green <= g;
		pix_ch.blue <= b;
		pix_ch.frame_start <= fs;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		predict_edge(px);
		pixels_sent++;
	endtask

	// channel values lean toward the extremes now and then
	function automatic logic [PIX_W-1:0] rand_channel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_pixel(input logic fs);
		send_pixel(rand_channel(), rand_channel(), rand_channel(), fs);
	endtask

	// stop the pixel stream and let every owed gradient and any bubble drain out
	task automatic wait_idle();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_edges.size() != 0)
			@(posedge clk);
		drain_hold <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_frame_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_reg = value;
		else if (idx == REG_FRAME_HEIGHT)
			height_reg = value;
		reg_writes++;
		drain_hold <= 1'b0;
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		write_frame_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_frame_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
	endtask

	// reset geometry: the first pixels land in row 0 of the wide reset frame
	task automatic test_reset_geometry();
		// no frame start: the reset position must already be column 0 row 0
		for (int k = 0; k < 24; k++)
			send_random_pixel(1'b0);
		// narrowing mid-row, the column is already past the new width and wraps
		write_frame_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
		for (int k = 0; k < 30; k++)
			send_random_pixel(1'b0);
	endtask

	// hand-made 5x5 frame: channel extremes, truncation of the mean, saturation both ways
	task automatic test_directed_pixels();
		logic [3*PIX_W-1:0] colors [25] = '{
			24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE,
			24'h000000, 24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
			24'h0000FF, 24'h010100, 24'h020202, 24'h804020, 24'hFFFFFF,
			24'h000000, 24'h000000, 24'h000000, 24'hAA5555, 24'hFFFFFF
		};
		set_frame(5, 5);
		for (int k = 0; k < 25; k++)
			send_pixel(colors[k][23:16], colors[k][15:8], colors[k][7:0], k == 0);
	endtask

	// sizes below the minimum, all-ones registers, a steady stretch and a mid-frame height cut
	task automatic test_size_limits();
		set_frame(0, 1);
		// second frame follows without a frame start, by wrap alone
		for (int k = 0; k < 18; k++)
			send_random_pixel(k == 0);
		set_frame(2, 2);
		for (int k = 0; k < 9; k++)
			send_random_pixel(k == 0);

		// all ones acts as the largest width: no wrap in the first row, then narrowed
		set_frame(4095, 3);
		for (int k = 0; k < 40; k++)
			send_random_pixel(k == 0);
		write_frame_reg(REG_FRAME_WIDTH, CFG_DATA_W'(5));
		for (int k = 0; k < 20; k++)
			send_random_pixel(1'b0);

		// all ones acts as the largest height
		set_frame(3, 4095);
		for (int k = 0; k < 30; k++)
			send_random_pixel(k == 0);

		// a stretch with no idling at all
		set_frame(12, 6);
		steady <= 1'b1;
		for (int k = 0; k < 72; k++)
			send_random_pixel(k == 0);
		steady <= 1'b0;

		// the row is past the new height and wraps to row 0
		set_frame(5, 8);
		for (int k = 0; k < 32; k++)
			send_random_pixel(k == 0);
		write_frame_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(4));
		for (int k = 0; k < 25; k++)
			send_random_pixel(1'b0);
	endtask

	// frame start in mid-row, twice in a row, then a full frame after it
	task automatic test_midframe_restart();
		set_frame(6, 6);
		for (int k = 0; k < 14; k++)
			send_random_pixel(k == 0);
		send_random_pixel(1'b1);
		send_random_pixel(1'b1);
		for (int k = 0; k < 40; k++)
			send_random_pixel(1'b0);
	endtask

	// writes to the unused indexes leave the frame size alone
	task automatic test_spare_registers();
		write_frame_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 4095)));
		write_frame_reg(REG_SPARE_B, '1);
		for (int k = 0; k < 36; k++)
			send_random_pixel(k == 0);
	endtask

	// random frames: mostly whole, some cut short, some running into the next frame
	task automatic test_random_frames();
		int unsigned sent;
		int unsigned w, h, n;
		sent = 0;
		while (sent < 180) begin
			// now and then keep the geometry so frames follow back to back
			if ($urandom_range(0, 9) >= 3) begin
				case ($urandom_range(0, 9))
					0: w = $urandom_range(0, 2);
					1: w = $urandom_range(13, 40);
					default: w = $urandom_range(3, 12);
				endcase
				h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
				set_frame(w, h);
			end
			n = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, HEIGHT_MAX);
			case ($urandom_range(0, 9))
				0: n = $urandom_range(1, n - 1);
				1: n = n + $urandom_range(1, 2 * clamp_dim(width_reg, MAX_WIDTH));
				default: ;
			endcase
			// a stray frame start breaks the odd frame
			for (int k = 0; k < n; k++)
				send_random_pixel(k == 0 || $urandom_range(0, 99) < 2);
			sent += n;
		end
	endtask

	// result side: random stalls, held open while draining or in a steady stretch
	always @(posedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else if (steady || drain_hold)
			res_ch.ready <= 1'b1;
		else
			res_ch.ready <= ($urandom_range(0, 99) >= 15);
	end

	// compare every result transaction with the oldest owed gradient
	always @(posedge clk) begin : check_results
		edge_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_edges.size() == 0) begin
				report_mismatch($sformatf("unexpected result col %0d row %0d gradient %0d",
					res_ch.out_col, res_ch.out_row, res_ch.gradient));
			end else begin
				want = pending_edges.pop_front();
				results_checked++;
				if (res_ch.gradient !== want.gradient)
					report_mismatch($sformatf("gradient at col %0d row %0d: got %0d want %0d",
						want.col, want.row, res_ch.gradient, want.gradient));
				if (res_ch.out_col !== want.col)
					report_mismatch($sformatf("out_col: got %0d want %0d",
						res_ch.out_col, want.col));
				if (res_ch.out_row !== want.row)
					report_mismatch($sformatf("out_row: got %0d want %0d",
						res_ch.out_row, want.row));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results owed",
				cycle_count, pending_edges.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : run_tests
		int unsigned waited;
		// known values on every input from time zero, result ready comes from its own process
		pix_ch.valid <= 1'b0;
		pix_ch.red <= '0;
		pix_ch.green <= '0;
		pix_ch.blue <= '0;
		pix_ch.frame_start <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_FRAME_WIDTH;
		cfg_ch.data <= '0;

		// predictor out of reset; line buffers zero, only border centers ever see them unwritten
		for (int k = 0; k < MAX_WIDTH; k++) begin
			lum_two_up[k] = '0;
			lum_one_up[k] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				win[r][c] = '0;
		scan_col = 0;
		scan_row = 0;
		width_reg = FRAME_WIDTH_RST;
		height_reg = FRAME_HEIGHT_RST;

		// single reset at the start of the run
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_directed_pixels();
		test_size_limits();
		test_midframe_restart();
		test_spare_registers();
		test_random_frames();

		// drain: bounded wait for owed gradients, then a quiet tail for strays
		pix_ch.valid <= 1'b0;
		waited = 0;
		while (pending_edges.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		drain_hold <= 1'b1;
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (pending_edges.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_edges.size()));

		$display("sent %0d pixels over %0d register writes, checked %0d gradients",
			pixels_sent, reg_writes, results_checked);
		$display("sizes from clamped minimum to all-ones registers, restarts and wraps, %0d cycles",
			cycle_count);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sobel_edge_filter_rgb_top.f]
+incdir+hw/rtl
hw/rtl/sobel_rgb_pkg.sv
hw/rtl/sobel_rgb_ifs.sv
hw/rtl/sobel_rgb_line_ram.sv
hw/rtl/sobel_rgb_scan.sv
hw/rtl/sobel_rgb_window.sv
hw/rtl/sobel_edge_filter_rgb_top.sv
test/testbench.sv
